@@ sv/vak_pkg.sv @@
package vak_pkg;

  // Default sizes, handed to the top level parameters
  localparam int VOICE_COUNT_DEF = 8;
  localparam int KEY_COUNT_DEF   = 128;

  // Fixed field widths
  localparam int TIME_W  = 32;
  localparam int KEY_W   = 7;
  localparam int VEL_W   = 7;
  localparam int VIDX_W  = 3;

  // Velocity curve breakpoints and offsets
  localparam logic [TIME_W-1:0] CURVE_T0 = 32'd20;
  localparam logic [TIME_W-1:0] CURVE_T1 = 32'd160;
  localparam logic [TIME_W-1:0] CURVE_T2 = 32'd768;
  localparam logic [TIME_W-1:0] CURVE_T3 = 32'd3050;
  localparam logic [7:0]        VEL_MAX  = 8'd127;
  localparam logic [7:0]        VEL_OFS1 = 8'd137;
  localparam logic [7:0]        VEL_OFS2 = 8'd67;
  localparam logic [7:0]        VEL_OFS3 = 8'd25;
  localparam logic [7:0]        VEL_MIN  = 8'd1;

  // Event kind
  typedef enum logic [0:0] {
    REQ_DOWN = 1'b0,
    REQ_UP   = 1'b1
  } req_t;

  // Envelope command
  typedef enum logic [0:0] {
    ENV_START   = 1'b0,
    ENV_RELEASE = 1'b1
  } env_cmd_t;

  // Control from the event stage to the voice ring
  typedef struct packed {
    logic fire;
    req_t req;
  } ring_ctl_t;

  // Piecewise velocity curve: 127 for fast strikes down to 1 for slow ones
  function automatic logic [VEL_W-1:0] vak_curve(input logic [TIME_W-1:0] t);
    logic [7:0] r;
    if (t < CURVE_T0) begin
      r = VEL_MAX;
    end else if (t < CURVE_T1) begin
      r = VEL_OFS1 - {1'b0, t[7:1]};
    end else if (t < CURVE_T2) begin
      r = VEL_OFS2 - {2'b00, t[9:4]};
    end else if (t < CURVE_T3) begin
      r = VEL_OFS3 - {3'b000, t[11:7]};
    end else begin
      r = VEL_MIN;
    end
    return r[VEL_W-1:0];
  endfunction

endpackage

@@ sv/vak_ram.sv @@
module vak_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/vak_ring.sv @@
module vak_ring #(
  parameter int VOICE_COUNT = vak_pkg::VOICE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  vak_pkg::ring_ctl_t             ctl,
  input  logic [$clog2(VOICE_COUNT)-1:0] key_voice,
  output logic [$clog2(VOICE_COUNT)-1:0] voice
);
  import vak_pkg::*;

  localparam int VW = $clog2(VOICE_COUNT);

  logic [VOICE_COUNT-1:0] voice_on, voice_on_next;
  logic [VW-1:0]          link [VOICE_COUNT];
  logic [VW-1:0]          link_next [VOICE_COUNT];
  logic [VW-1:0]          oldest, oldest_next;
  logic [VW-1:0]          youngest, youngest_next;
  logic                   steal;

  // Pick the voice and update the age ring
  always_comb begin
    voice         = (ctl.req == REQ_UP) ? key_voice : oldest;
    steal         = (ctl.req == REQ_DOWN) && voice_on[voice];
    voice_on_next = voice_on;
    link_next     = link;
    oldest_next   = oldest;
    youngest_next = youngest;
    if (ctl.fire) begin
      // released or stolen voice becomes the youngest
      if (ctl.req == REQ_UP || steal) begin
        link_next[youngest] = voice;
        youngest_next       = voice;
      end
      if (ctl.req == REQ_UP) begin
        voice_on_next[voice] = 1'b0;
      end else begin
        voice_on_next[voice] = 1'b1;
        // follow the link as just written (self link when stealing the youngest)
        oldest_next = (steal && youngest == voice) ? voice : link[voice];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_on <= '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        link[i] <= VW'((i + 1) % VOICE_COUNT);
      end
      oldest   <= '0;
      youngest <= VW'(VOICE_COUNT - 1);
    end else begin
      voice_on <= voice_on_next;
      link     <= link_next;
      oldest   <= oldest_next;
      youngest <= youngest_next;
    end
  end

endmodule

@@ sv/voice_allocator_with_velocity_curve_unit.sv @@
// Voice allocator with velocity curve.
// Command channel: an event (req_type, switch_time, key_number) transfers at a
// rising edge with start high and busy low. Key-down starts the oldest voice
// (stealing it if on); key-up releases the voice recorded for the key.
// Result channel: done is high for exactly one cycle with env_command,
// voice_index, key_out and velocity; that cycle's closing edge is the transfer.
// The receiver cannot stall; results are never held.
// Path: a transferred event is registered in the event stage, and its result
// in the result register. Throughput: one event every cycle while busy is low;
// the key-to-voice table read is the registered table memory read, so one
// pipeline stage sits ahead of the ring update, forwarding same-key writes.
// Events with a key at or beyond KEY_COUNT change nothing and give no result.
// Reset (rst, synchronous): voices off, ring in index order, all keys map to
// voice 0; busy is high during reset and in the cycle after it.
module voice_allocator_with_velocity_curve_unit #(
  parameter int VOICE_COUNT = vak_pkg::VOICE_COUNT_DEF,
  parameter int KEY_COUNT   = vak_pkg::KEY_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [vak_pkg::TIME_W-1:0]    switch_time,
  input  logic [vak_pkg::KEY_W-1:0]     key_number,
  output logic                          done,
  output logic                          env_command,
  output logic [vak_pkg::VIDX_W-1:0]    voice_index,
  output logic [vak_pkg::KEY_W-1:0]     key_out,
  output logic [vak_pkg::VEL_W-1:0]     velocity
);
  import vak_pkg::*;

  localparam int VW = $clog2(VOICE_COUNT);
  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  logic              accept;
  logic              key_in_range;
  logic [KW-1:0]     key_idx_in;
  logic              s1_valid;
  req_t              s1_req;
  logic [TIME_W-1:0] s1_time;
  logic [KEY_W-1:0]  s1_key;
  logic [KW-1:0]     s1_key_idx;
  logic              fwd_hit;
  logic [VW-1:0]     fwd_voice;
  logic [KEY_COUNT-1:0] key_valid;
  logic [VW-1:0]     ram_rdata;
  logic [VW-1:0]     key_voice;
  logic [VW-1:0]     voice;
  logic              kv_we;
  ring_ctl_t         ctl;

  // Hold off commands through reset and the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept       = start && !busy;
  assign key_in_range = 32'(key_number) < KEY_COUNT;
  assign key_idx_in   = KW'(key_number);
  assign s1_key_idx   = KW'(s1_key);

  // Event stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= accept && key_in_range;
      fwd_hit  <= kv_we && (key_idx_in == s1_key_idx);
    end
    s1_req    <= req_t'(req_type);
    s1_time   <= switch_time;
    s1_key    <= key_number;
    fwd_voice <= voice;
  end

  // Key to voice table, read at transfer time
  vak_ram #(
    .WIDTH (VW),
    .DEPTH (KEY_COUNT)
  ) u_key_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (s1_key_idx),
    .wdata (voice),
    .raddr (key_idx_in),
    .rdata (ram_rdata)
  );

  // Unwritten keys read as voice 0; newest write wins
  always_comb begin
    if (fwd_hit) begin
      key_voice = fwd_voice;
    end else if (key_valid[s1_key_idx]) begin
      key_voice = ram_rdata;
    end else begin
      key_voice = '0;
    end
  end

  assign ctl.fire = s1_valid;
  assign ctl.req  = s1_req;
  assign kv_we    = s1_valid && (s1_req == REQ_DOWN);

  vak_ring #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .key_voice (key_voice),
    .voice     (voice)
  );

  // Written-key flags
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= '0;
    end else if (kv_we) begin
      key_valid[s1_key_idx] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    env_command <= (s1_req == REQ_UP) ? 1'(ENV_RELEASE) : 1'(ENV_START);
    voice_index <= VIDX_W'(voice);
    key_out     <= (s1_req == REQ_UP) ? '0 : s1_key;
    velocity    <= vak_curve(s1_time);
  end

`ifndef SYNTHESIS
  a_done_follows_event: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid))
    else $error("result without an event");

  a_release_no_key: assert property (@(posedge clk) disable iff (rst)
    (done && env_command == 1'(ENV_RELEASE)) |-> key_out == '0)
    else $error("release carries a key");

  a_velocity_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> velocity != '0)
    else $error("velocity out of range");

  a_fwd_only_with_event: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> $past(kv_we))
    else $error("forward without table write");
`endif

endmodule

@@ test/voice_allocator_with_velocity_curve_unit_tb.sv @@
module voice_allocator_with_velocity_curve_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vak_pkg::*;

  localparam int VOICES  = VOICE_COUNT_DEF;
  localparam int KEYS    = KEY_COUNT_DEF;
  localparam int LATENCY = 2;

  // One envelope command as the block should emit it
  typedef struct {
    env_cmd_t            cmd;
    logic [VIDX_W-1:0]   voice;
    logic [KEY_W-1:0]    key;
    logic [VEL_W-1:0]    vel;
  } env_cmd_item_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               req_type;
  logic [TIME_W-1:0]  switch_time;
  logic [KEY_W-1:0]   key_number;
  logic               done;
  logic               env_command;
  logic [VIDX_W-1:0]  voice_index;
  logic [KEY_W-1:0]   key_out;
  logic [VEL_W-1:0]   velocity;

  // Allocator state as predicted by the testbench
  logic               voice_active [VOICES];
  logic [VIDX_W-1:0]  ring_next    [VOICES];
  logic [VIDX_W-1:0]  oldest_ptr;
  logic [VIDX_W-1:0]  youngest_ptr;
  logic [VIDX_W-1:0]  key_voice    [KEYS];

  env_cmd_item_t      pending_cmds[$];
  logic [KEY_W-1:0]   held_keys[$];

  int errors;
  int cmds_checked;
  int key_downs;
  int key_ups;
  int steals;

  voice_allocator_with_velocity_curve_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .switch_time (switch_time),
    .key_number  (key_number),
    .done        (done),
    .env_command (env_command),
    .voice_index (voice_index),
    .key_out     (key_out),
    .velocity    (velocity)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Velocity from strike time, piecewise
  function automatic logic [VEL_W-1:0] velocity_for(input logic [TIME_W-1:0] t);
    int unsigned v;
    if (t < CURVE_T0) begin
      v = 32'(VEL_MAX);
    end else if (t < CURVE_T1) begin
      v = 32'(VEL_OFS1) - (t / 2);
    end else if (t < CURVE_T2) begin
      v = 32'(VEL_OFS2) - (t / 16);
    end else if (t < CURVE_T3) begin
      v = 32'(VEL_OFS3) - (t / 128);
    end else begin
      v = 32'(VEL_MIN);
    end
    return v[VEL_W-1:0];
  endfunction

  // Update the allocator state for one event and queue its command
  task automatic predict_event(input req_t kind, input logic [TIME_W-1:0] t,
                               input logic [KEY_W-1:0] key);
    logic [VIDX_W-1:0] v;
    env_cmd_item_t     c;
    c.vel = velocity_for(t);
    if (kind == REQ_DOWN) begin
      v = oldest_ptr;
      if (voice_active[v]) begin
        // steal: relink as youngest before following the link
        ring_next[youngest_ptr] = v;
        youngest_ptr = v;
        steals++;
      end else begin
        voice_active[v] = 1'b1;
      end
      oldest_ptr = ring_next[v];
      key_voice[key] = v;
      c.cmd = ENV_START;
      c.key = key;
      key_downs++;
    end else begin
      // release: only the youngest link moves, old place stays linked
      v = key_voice[key];
      voice_active[v] = 1'b0;
      ring_next[youngest_ptr] = v;
      youngest_ptr = v;
      c.cmd = ENV_RELEASE;
      c.key = '0;
      key_ups++;
    end
    c.voice = v;
    pending_cmds.push_back(c);
  endtask

  // Drive one event and hold it until the transfer
  task automatic send_event(input req_t kind, input logic [TIME_W-1:0] t,
                            input logic [KEY_W-1:0] key);
    @(negedge clk);
    start       <= 1'b1;
    req_type    <= kind;
    switch_time <= t;
    key_number  <= key;
    do @(posedge clk); while (busy);
    predict_event(kind, t, key);
  endtask

  // Sender gap with junk on the fields
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start       <= 1'b0;
      req_type    <= 1'($urandom_range(0, 1));
      switch_time <= $urandom;
      key_number  <= KEY_W'($urandom_range(0, KEYS - 1));
    end
  endtask

  function automatic logic [TIME_W-1:0] random_strike_time();
    logic [TIME_W-1:0] t;
    case ($urandom_range(0, 6))
      0: t = $urandom;
      1: t = $urandom_range(0, 19);
      2: t = $urandom_range(20, 159);
      3: t = $urandom_range(160, 767);
      4: t = $urandom_range(768, 3049);
      5: t = $urandom_range(3050, 5000);
      default: begin
        case ($urandom_range(0, 3))
          0: t = CURVE_T0;
          1: t = CURVE_T1;
          2: t = CURVE_T2;
          default: t = CURVE_T3;
        endcase
        t = t + $urandom_range(0, 2) - 1;
      end
    endcase
    return t;
  endfunction

  // Mostly a small pool of keys so the same key repeats often
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 7))
      0: k = KEY_W'(KEYS - 1);
      1, 2: k = KEY_W'($urandom_range(0, KEYS - 1));
      default: k = KEY_W'($urandom_range(0, 11));
    endcase
    return k;
  endfunction

  // Result checker: each strobe pops the oldest expected command
  always @(posedge clk) begin
    env_cmd_item_t c;
    if (!rst && done) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected command: env_command=%0d voice_index=%0d key_out=%0d velocity=%0d",
               env_command, voice_index, key_out, velocity);
        errors++;
      end else begin
        c = pending_cmds.pop_front();
        cmds_checked++;
        if (env_command !== c.cmd) begin
          $error("env_command: expected %0d, got %0d", c.cmd, env_command);
          errors++;
        end
        if (voice_index !== c.voice) begin
          $error("voice_index: expected %0d, got %0d", c.voice, voice_index);
          errors++;
        end
        if (key_out !== c.key) begin
          $error("key_out: expected %0d, got %0d", c.key, key_out);
          errors++;
        end
        if (velocity !== c.vel) begin
          $error("velocity: expected %0d, got %0d", c.vel, velocity);
          errors++;
        end
      end
    end
  end

  // Stale key-up after reset, self-linked youngest, steal of the youngest
  task automatic test_ring_corners();
    send_event(REQ_UP, 32'd5, 7'd5);
    send_event(REQ_UP, 32'd5, 7'd5);
    send_event(REQ_DOWN, 32'd40, 7'd64);
    send_event(REQ_DOWN, 32'd41, 7'd65);
    send_event(REQ_UP, 32'd3000, 7'd64);
  endtask

  // Every segment of the curve, both ends of each
  task automatic test_velocity_curve();
    logic [TIME_W-1:0] pts[12];
    int i;
    pts = '{32'd0, 32'd19, 32'd20, 32'd21, 32'd158, 32'd159, 32'd160, 32'd767,
            32'd768, 32'd3049, 32'd3050, 32'hFFFF_FFFF};
    for (i = 0; i < 12; i++) begin
      if (i % 3 == 2)
        send_event(REQ_UP, pts[i], (i % 2) ? 7'd127 : 7'd0);
      else
        send_event(REQ_DOWN, pts[i], (i % 2) ? 7'd127 : 7'd0);
    end
  endtask

  // Same key in consecutive cycles, through the key table forwarding
  task automatic test_same_key_back_to_back();
    send_event(REQ_DOWN, 32'h8000_0000, 7'd77);
    send_event(REQ_UP,   32'h5555_5555, 7'd77);
    send_event(REQ_DOWN, 32'hAAAA_AAAA, 7'd77);
    send_event(REQ_DOWN, 32'd100, 7'd78);
    send_event(REQ_UP,   32'd100, 7'd78);
    send_event(REQ_UP,   32'd100, 7'd77);
  endtask

  // Random key traffic, mostly well-formed press/release with some stale ups
  task automatic test_random_traffic(input int count, input bit with_gaps);
    int i;
    int pick;
    int idx;
    bit gaps_now;
    logic [KEY_W-1:0] key;
    gaps_now = 1'b0;
    i = 0;
    while (i < count) begin
      if (i % 50 == 0)
        gaps_now = with_gaps && ($urandom_range(0, 3) != 0);
      if (gaps_now && $urandom_range(0, 4) == 0)
        idle_cycles($urandom_range(1, 17));
      pick = $urandom_range(0, 99);
      if (held_keys.size() > 24 && pick < 50)
        pick = pick + 50;
      if (pick < 50 || (held_keys.size() == 0 && pick < 85)) begin
        key = random_key();
        send_event(REQ_DOWN, random_strike_time(), key);
        held_keys.push_back(key);
      end else if (pick < 85) begin
        idx = $urandom_range(0, held_keys.size() - 1);
        key = held_keys[idx];
        held_keys.delete(idx);
        send_event(REQ_UP, random_strike_time(), key);
      end else if (pick < 93) begin
        send_event(REQ_UP, random_strike_time(), KEY_W'($urandom_range(0, KEYS - 1)));
      end else begin
        key = random_key();
        send_event(REQ_DOWN, random_strike_time(), key);
        send_event(REQ_UP, random_strike_time(), key);
        i++;
      end
      i++;
    end
  endtask

  initial begin
    int n;
    rst         = 1'b1;
    start       = 1'b0;
    req_type    = REQ_DOWN;
    switch_time = '0;
    key_number  = '0;
    errors       = 0;
    cmds_checked = 0;
    key_downs    = 0;
    key_ups      = 0;
    steals       = 0;
    for (n = 0; n < VOICES; n++) begin
      voice_active[n] = 1'b0;
      ring_next[n]    = VIDX_W'((n + 1) % VOICES);
    end
    oldest_ptr   = '0;
    youngest_ptr = VIDX_W'(VOICES - 1);
    for (n = 0; n < KEYS; n++)
      key_voice[n] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ring_corners();
    test_velocity_curve();
    test_same_key_back_to_back();
    test_random_traffic(1500, 1'b1);
    test_random_traffic(500, 1'b0);

    @(negedge clk);
    start <= 1'b0;

    // drain, bounded
    n = 0;
    while (pending_cmds.size() != 0 && n < 1000) begin
      @(posedge clk);
      n++;
    end
    if (pending_cmds.size() != 0) begin
      $error("%0d commands never arrived", pending_cmds.size());
      $display("end of test: mismatches");
    end else begin
      repeat (LATENCY + 4) @(posedge clk);
      $display("covered %0d key-downs (%0d voice steals) and %0d key-ups",
               key_downs, steals, key_ups);
      $display("%0d envelope commands checked, %0d errors", cmds_checked, errors);
      if (errors == 0)
        $display("end of test: clean");
      else
        $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
